[sv/pch_pkg.sv]
// Package for the legacy PC port hub: transaction structs, request codes,
// port addresses and the axis count helper. No dependencies.
package pch_pkg;

  localparam int unsigned PCH_NUM_AXES   = 4;
  localparam int unsigned PCH_MAX_AXES   = 4;
  localparam int unsigned PCH_PROD_W     = 26;
  localparam int unsigned PCH_CNT_W      = 10;

  typedef enum logic [2:0] {
    REQ_PORT_WR    = 3'd0,
    REQ_PORT_RD    = 3'd1,
    REQ_RAISE_IRQ  = 3'd2,
    REQ_TAKE_VEC   = 3'd3,
    REQ_JOY_UPDATE = 3'd4
  } pch_req_e;

  localparam logic [15:0] PCH_PORT_GAME     = 16'h0201;
  localparam logic [15:0] PCH_PORT_MASK_MST = 16'h0021;
  localparam logic [15:0] PCH_PORT_MASK_SLV = 16'h00A1;
  localparam logic [15:0] PCH_PORT_SPK_CTRL = 16'h0061;
  localparam logic [15:0] PCH_PORT_TMR_CH2  = 16'h0042;
  localparam logic [15:0] PCH_PORT_TMR_CTRL = 16'h0043;

  localparam logic [1:0] TMR_SEL_CH2   = 2'd2;
  localparam logic [1:0] TMR_ACC_LATCH = 2'd0;
  localparam logic [1:0] TMR_ACC_LSB   = 2'd1;
  localparam logic [1:0] TMR_ACC_MSB   = 2'd2;
  localparam logic [1:0] TMR_ACC_ALT   = 2'd3;

  localparam logic [7:0] PCH_VEC_BASE_MST = 8'h08;
  localparam logic [7:0] PCH_VEC_BASE_SLV = 8'h70;
  localparam int unsigned PCH_CASCADE_BIT = 2;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [15:0]        port_addr;
    logic [7:0]         write_data;
    logic [3:0]         irq_line;
    logic signed [15:0] axis_pos0;
    logic signed [15:0] axis_pos1;
    logic signed [15:0] axis_pos2;
    logic signed [15:0] axis_pos3;
    logic [3:0]         button_bits;
    logic               stick_present;
  } pch_req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        read_handled;
    logic [7:0]  vector_num;
    logic        vector_valid;
    logic [15:0] speaker_reload;
    logic        speaker_on;
  } pch_rsp_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] num;
  } pch_vec_t;

  // 6 + floor(prod / 65535), prod = offset * 1000 < 2^26.
  // prod = q*65535 + (q + r) with q = prod >> 16, r = low 16 bits; q + r < 2*65535.
  function automatic logic [PCH_CNT_W-1:0] pch_stick_ticks(input logic [PCH_PROD_W-1:0] prod);
    logic [PCH_CNT_W-1:0] q;
    logic [16:0]          s;
    logic                 inc;
    q   = prod[PCH_PROD_W-1:16];
    s   = {7'd0, q} + {1'b0, prod[15:0]};
    inc = (s >= 17'd65535);
    return q + {{(PCH_CNT_W-1){1'b0}}, inc} + PCH_CNT_W'(6);
  endfunction

  // Centered stick: offset 32768.
  localparam logic [PCH_CNT_W-1:0] PCH_AXIS_RESET = pch_stick_ticks(PCH_PROD_W'(32768 * 1000));

endpackage

[sv/pch_in_stage.sv]
// Input register of the port hub; also forms the axis offset products.
// Depends on pch_pkg.
module pch_in_stage #(
  parameter int unsigned NUM_AXES = pch_pkg::PCH_NUM_AXES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  pch_pkg::pch_req_t    req_i,
  input  logic                 advance_i,
  output logic                 item_valid_o,
  output pch_pkg::pch_req_t    item_o,
  output logic [NUM_AXES-1:0][pch_pkg::PCH_PROD_W-1:0] prod_o
);
  import pch_pkg::*;

  logic                                   valid_q, valid_d;
  logic                                   accept;
  pch_req_t                               item_q;
  logic [NUM_AXES-1:0][PCH_PROD_W-1:0]    prod_q;
  logic [PCH_MAX_AXES-1:0][15:0]          pos;

  assign req_ready_o = !valid_q || advance_i;
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  assign pos = {req_i.axis_pos3, req_i.axis_pos2, req_i.axis_pos1, req_i.axis_pos0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_prod
    logic [15:0] offs;
    // pos + 32768 is the sign bit flipped
    assign offs = {~pos[a][15], pos[a][14:0]};
    always_ff @(posedge clk_i) begin
      if (accept) begin
        prod_q[a] <= PCH_PROD_W'(offs) * PCH_PROD_W'(1000);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= req_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;
  assign prod_o       = prod_q;

endmodule

[sv/pch_pic.sv]
// Interrupt mask registers, pending latch and lowest-line vector pick.
// Depends on pch_pkg.
module pch_pic (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  pch_pkg::pch_req_t item_i,
  output logic [7:0]        mask_master_o,
  output logic [7:0]        mask_slave_o,
  output pch_pkg::pch_vec_t vec_o
);
  import pch_pkg::*;

  logic [7:0]  mask_master_q, mask_master_d;
  logic [7:0]  mask_slave_q, mask_slave_d;
  logic [15:0] pending_q, pending_d;
  logic [15:0] masked, elig;
  logic [3:0]  idx;
  logic        is_wr;

  assign masked = {mask_slave_q | {8{mask_master_q[PCH_CASCADE_BIT]}}, mask_master_q};
  assign elig   = pending_q & ~masked;

  always_comb begin
    idx = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (elig[i]) begin
        idx = 4'(i);
      end
    end
  end

  always_comb begin
    vec_o.valid = (item_i.req_type == REQ_TAKE_VEC) && (|elig);
    vec_o.num   = 8'h00;
    if (vec_o.valid) begin
      vec_o.num = (idx[3] ? PCH_VEC_BASE_SLV : PCH_VEC_BASE_MST) + {5'd0, idx[2:0]};
    end
  end

  assign is_wr = item_i.req_type == REQ_PORT_WR;

  always_comb begin
    mask_master_d = mask_master_q;
    mask_slave_d  = mask_slave_q;
    pending_d     = pending_q;
    if (fire_i) begin
      if (is_wr && item_i.port_addr == PCH_PORT_MASK_MST) begin
        mask_master_d = item_i.write_data;
      end
      if (is_wr && item_i.port_addr == PCH_PORT_MASK_SLV) begin
        mask_slave_d = item_i.write_data;
      end
      if (item_i.req_type == REQ_RAISE_IRQ) begin
        pending_d = pending_q | (16'd1 << item_i.irq_line);
      end
      if (vec_o.valid) begin
        pending_d = pending_q & ~(16'd1 << idx);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_master_q <= 8'hFF;
      mask_slave_q  <= 8'hFF;
      pending_q     <= 16'h0000;
    end else begin
      mask_master_q <= mask_master_d;
      mask_slave_q  <= mask_slave_d;
      pending_q     <= pending_d;
    end
  end

  assign mask_master_o = mask_master_q;
  assign mask_slave_o  = mask_slave_q;

endmodule

[sv/pch_gameport.sv]
// Game port: axis counts, one-shot counters, buttons and presence flag.
// Depends on pch_pkg.
module pch_gameport #(
  parameter int unsigned NUM_AXES = pch_pkg::PCH_NUM_AXES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  pch_pkg::pch_req_t item_i,
  input  logic [NUM_AXES-1:0][pch_pkg::PCH_PROD_W-1:0] prod_i,
  output logic [7:0]        rd_data_o
);
  import pch_pkg::*;

  logic [NUM_AXES-1:0][PCH_CNT_W-1:0]   count_q, count_d;
  logic [NUM_AXES-1:0][PCH_CNT_W-1:0]   shot_q, shot_d;
  logic [3:0]                           button_q, button_d;
  logic                                 present_q, present_d;
  logic                                 game_port, do_load, do_read, do_update;

  assign game_port = item_i.port_addr == PCH_PORT_GAME;
  assign do_load   = fire_i && item_i.req_type == REQ_PORT_WR && game_port;
  assign do_read   = fire_i && item_i.req_type == REQ_PORT_RD && game_port && present_q;
  assign do_update = fire_i && item_i.req_type == REQ_JOY_UPDATE;

  always_comb begin
    rd_data_o = {~button_q, 4'b0000};
    for (int a = 0; a < NUM_AXES; a++) begin
      rd_data_o[a] = |shot_q[a];
    end
    if (!present_q) begin
      rd_data_o = 8'hFF;
    end
  end

  always_comb begin
    count_d   = count_q;
    shot_d    = shot_q;
    button_d  = button_q;
    present_d = present_q;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (do_update) begin
        count_d[a] = pch_stick_ticks(prod_i[a]);
      end
      if (do_load) begin
        shot_d[a] = count_q[a];
      end else if (do_read && (|shot_q[a])) begin
        shot_d[a] = shot_q[a] - PCH_CNT_W'(1);
      end
    end
    if (do_update) begin
      button_d  = item_i.button_bits;
      present_d = item_i.stick_present;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= {NUM_AXES{PCH_AXIS_RESET}};
      shot_q    <= '0;
      button_q  <= 4'd0;
      present_q <= 1'b1;
    end else begin
      count_q   <= count_d;
      shot_q    <= shot_d;
      button_q  <= button_d;
      present_q <= present_d;
    end
  end

endmodule

[sv/pc_legacy_port_hub.sv]
// Legacy PC port hub: interrupt masks and vectors, timer channel 2 reload,
// speaker control and game port, one result transaction per request.
// Result path: input register, then result register. Throughput: one transaction per
// cycle while results are taken; all state updates happen in one pass of the second
// stage. Reset: masks 0xFF, timer access alternating low/high, stick present, sticks
// centered, everything else zero. Depends on pch_pkg and the pch_* modules.
module pc_legacy_port_hub #(
  parameter int unsigned NUM_AXES = pch_pkg::PCH_NUM_AXES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  pch_pkg::pch_req_t req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output pch_pkg::pch_rsp_t rsp_o
);
  import pch_pkg::*;

  logic                                  item_valid, out_free, fire;
  pch_req_t                              item;
  logic [NUM_AXES-1:0][PCH_PROD_W-1:0]   prod;
  logic [7:0]                            mask_master, mask_slave, game_data;
  pch_vec_t                              vec;

  logic [15:0] reload_q, reload_d;
  logic [1:0]  acc_mode_q, acc_mode_d;
  logic        phase_q, phase_d;
  logic [7:0]  spk_ctrl_q, spk_ctrl_d;
  logic        rsp_valid_q, rsp_valid_d;
  pch_rsp_t    rsp_q, rsp_d;
  logic        is_wr, is_rd;
  logic [7:0]  wd;

  assign out_free = !rsp_valid_q || rsp_ready_i;
  assign fire     = item_valid && out_free;

  pch_in_stage #(.NUM_AXES(NUM_AXES)) u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid_i),
    .req_ready_o  (req_ready_o),
    .req_i        (req_i),
    .advance_i    (fire),
    .item_valid_o (item_valid),
    .item_o       (item),
    .prod_o       (prod)
  );

  pch_pic u_pic (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .item_i        (item),
    .mask_master_o (mask_master),
    .mask_slave_o  (mask_slave),
    .vec_o         (vec)
  );

  pch_gameport #(.NUM_AXES(NUM_AXES)) u_gameport (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .item_i    (item),
    .prod_i    (prod),
    .rd_data_o (game_data)
  );

  assign is_wr = item.req_type == REQ_PORT_WR;
  assign is_rd = item.req_type == REQ_PORT_RD;
  assign wd    = item.write_data;

  // Timer channel 2 latch and speaker control
  always_comb begin
    reload_d   = reload_q;
    acc_mode_d = acc_mode_q;
    phase_d    = phase_q;
    spk_ctrl_d = spk_ctrl_q;
    if (fire && is_wr) begin
      if (item.port_addr == PCH_PORT_SPK_CTRL) begin
        spk_ctrl_d = wd;
      end
      if (item.port_addr == PCH_PORT_TMR_CTRL && wd[7:6] == TMR_SEL_CH2 &&
          wd[5:4] != TMR_ACC_LATCH) begin
        acc_mode_d = wd[5:4];
        phase_d    = 1'b0;
      end
      if (item.port_addr == PCH_PORT_TMR_CH2) begin
        unique case (acc_mode_q)
          TMR_ACC_LSB: reload_d = {8'h00, wd};
          TMR_ACC_MSB: reload_d = {wd, 8'h00};
          default: begin
            // latch code never reaches here after reset; treated as alternating
            if (!phase_q) begin
              reload_d = {reload_q[15:8], wd};
            end else begin
              reload_d = {wd, reload_q[7:0]};
            end
            phase_d = !phase_q;
          end
        endcase
      end
    end
  end

  always_comb begin
    rsp_d                = '0;
    rsp_d.speaker_reload = reload_d;
    rsp_d.speaker_on     = &spk_ctrl_d[1:0];
    rsp_d.vector_valid   = vec.valid;
    rsp_d.vector_num     = vec.num;
    if (is_rd) begin
      rsp_d.read_handled = 1'b1;
      unique case (item.port_addr)
        PCH_PORT_GAME:     rsp_d.read_data = game_data;
        PCH_PORT_MASK_MST: rsp_d.read_data = mask_master;
        PCH_PORT_MASK_SLV: rsp_d.read_data = mask_slave;
        PCH_PORT_SPK_CTRL: rsp_d.read_data = spk_ctrl_q;
        default:           rsp_d.read_handled = 1'b0;
      endcase
    end
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (fire) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q    <= 16'h0000;
      acc_mode_q  <= TMR_ACC_ALT;
      phase_q     <= 1'b0;
      spk_ctrl_q  <= 8'h00;
      rsp_valid_q <= 1'b0;
    end else begin
      reload_q    <= reload_d;
      acc_mode_q  <= acc_mode_d;
      phase_q     <= phase_d;
      spk_ctrl_q  <= spk_ctrl_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  a_vec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.vector_valid |->
      (rsp_o.vector_num[7:3] == 5'h01 || rsp_o.vector_num[7:3] == 5'h0E))
    else $error("vector number outside both controller ranges");

  a_unclaimed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.read_handled |-> rsp_o.read_data == 8'h00)
    else $error("unclaimed read carries data");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !(rsp_o.read_handled && rsp_o.vector_valid))
    else $error("read and vector in one transaction");

  a_reload_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> rsp_o.speaker_reload == reload_q)
    else $error("result reload differs from timer latch");

  a_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid && !fire |=> item_valid)
    else $error("pending request dropped from input register");

endmodule
